>>> hdl/csa_pkg.sv
// -----------------------------------------------------------------------------
// csa_pkg
// Constants shared by the sub-carrier amplitude unit: record geometry, slot
// mapping and field widths.
// -----------------------------------------------------------------------------
package csa_pkg;

   localparam int RAW_PAIRS   = 64;
   localparam int USED_SLOTS  = 52;
   localparam int HALF_SLOTS  = 26;
   localparam int NEG_BASE    = 38;

   localparam int PAIR_IDX_W  = $clog2(RAW_PAIRS);
   localparam int COUNT_W     = $clog2(RAW_PAIRS + 1);
   localparam int SLOT_W      = 6;
   localparam int PAIR_W      = 16;
   localparam int SAMPLE_W    = 8;
   localparam int AMP_W       = 16;
   localparam int RAD_W       = 2 * AMP_W;
   localparam int REM_W       = AMP_W + 2;
   localparam int STEP_W      = $clog2(AMP_W);
   localparam int ADDR_W      = 48;
   localparam int SEQ_W       = 32;

   localparam int AMP_MAX     = 46340;

endpackage

>>> hdl/csi_subcarrier_amplitude_unit.sv
// -----------------------------------------------------------------------------
// csi_subcarrier_amplitude_unit
// Collects a channel-state record of signed (imag, real) pairs into a 64-entry
// pair memory and, for a full record from the configured access point, emits
// 52 Q8.8 sub-carrier amplitudes computed by a bit-serial integer square root.
// -----------------------------------------------------------------------------
// Pairs are taken one per cycle while busy is low. On the last pair of a full
// record from the configured access point busy rises and the unit walks the
// pair memory: each amplitude takes a memory read (ST_READ), a square and sum
// (ST_LOAD) and sixteen square-root steps (ST_ROOT), one result bit per step,
// except slot 26 of a record flagged with a bad first word, which repeats
// slot 25. Each result is a single-cycle rsp_valid strobe and cannot be
// stalled; busy falls in the cycle that carries the last slot. Dropped
// records never raise busy.
module csi_subcarrier_amplitude_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [csa_pkg::SAMPLE_W-1:0] req_imag,
   input  logic signed [csa_pkg::SAMPLE_W-1:0] req_real_req,
   input  logic                              req_first_word_bad,
   input  logic [csa_pkg::ADDR_W-1:0]        req_frame_address,
   input  logic                              req_last_pair,
   output logic                              rsp_valid,
   output logic [csa_pkg::AMP_W-1:0]         rsp_amplitude,
   output logic [csa_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [csa_pkg::SEQ_W-1:0]         rsp_frame_sequence,
   output logic                              rsp_last_slot,
   input  logic                              csr_write_enable,
   input  logic [csa_pkg::ADDR_W-1:0]        csr_write_data
);

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_READ,
      ST_LOAD,
      ST_ROOT
   } state_type;

   state_type                          state_ff;
   logic [csa_pkg::ADDR_W-1:0]         ap_address_ff;
   logic [csa_pkg::COUNT_W-1:0]        pair_count_ff;
   logic                               flag_bad_ff;
   logic                               address_ok_ff;
   logic [csa_pkg::SEQ_W-1:0]          record_counter_ff;
   logic [csa_pkg::AMP_W-1:0]          prev_amp_ff;
   logic [csa_pkg::SLOT_W-1:0]         slot_ff;
   logic [csa_pkg::STEP_W-1:0]         step_ff;
   logic [csa_pkg::RAD_W-1:0]          rad_ff;
   logic [csa_pkg::REM_W-1:0]          rem_ff;
   logic [csa_pkg::AMP_W-1:0]          root_ff;
   logic                               rsp_valid_ff;
   logic [csa_pkg::AMP_W-1:0]          rsp_amplitude_ff;
   logic [csa_pkg::SLOT_W-1:0]         rsp_slot_ff;
   logic                               rsp_last_ff;

   logic [csa_pkg::PAIR_W-1:0]         pair_mem [csa_pkg::RAW_PAIRS];
   logic [csa_pkg::PAIR_W-1:0]         rd_data_ff;
   logic [csa_pkg::PAIR_IDX_W-1:0]     rd_addr;
   logic                               wr_en;

   logic                               accept;
   logic                               first_pair;
   logic                               address_ok_in;
   logic                               flag_bad_in;
   logic                               store_pair;
   logic [csa_pkg::COUNT_W-1:0]        pair_count_in;
   logic                               record_ok;

   logic signed [csa_pkg::PAIR_W-1:0]  im_sq;
   logic signed [csa_pkg::PAIR_W-1:0]  re_sq;
   logic [csa_pkg::PAIR_W:0]           power;
   logic [csa_pkg::RAD_W-1:0]          rad_in;
   logic [csa_pkg::REM_W+1:0]          rem_shift;
   logic [csa_pkg::REM_W+1:0]          trial;
   logic                               take_bit;
   logic [csa_pkg::REM_W-1:0]          rem_in;
   logic [csa_pkg::AMP_W-1:0]          root_in;
   logic                               last_step;
   logic                               repeat_slot;

   assign busy   = (state_ff != ST_COLLECT);
   assign accept = start && !busy;

   always_comb begin
      first_pair    = (pair_count_ff == '0);
      address_ok_in = first_pair ? (req_frame_address == ap_address_ff) : address_ok_ff;
      flag_bad_in   = first_pair ? req_first_word_bad : flag_bad_ff;
      store_pair    = (pair_count_ff < csa_pkg::COUNT_W'(csa_pkg::RAW_PAIRS));
      pair_count_in = store_pair ? pair_count_ff + 1'b1 : pair_count_ff;
      record_ok     = address_ok_in &&
                      (pair_count_in == csa_pkg::COUNT_W'(csa_pkg::RAW_PAIRS));
      wr_en         = accept && store_pair;
   end

   always_comb begin
      if (slot_ff < csa_pkg::SLOT_W'(csa_pkg::HALF_SLOTS)) begin
         rd_addr = csa_pkg::PAIR_IDX_W'(slot_ff + csa_pkg::SLOT_W'(csa_pkg::NEG_BASE));
      end else begin
         rd_addr = csa_pkg::PAIR_IDX_W'(slot_ff - csa_pkg::SLOT_W'(csa_pkg::HALF_SLOTS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[pair_count_ff[csa_pkg::PAIR_IDX_W-1:0]] <= {req_imag, req_real_req};
      end
      rd_data_ff <= pair_mem[rd_addr];
   end

   always_comb begin
      im_sq     = $signed(rd_data_ff[csa_pkg::PAIR_W-1:csa_pkg::SAMPLE_W]) *
                  $signed(rd_data_ff[csa_pkg::PAIR_W-1:csa_pkg::SAMPLE_W]);
      re_sq     = $signed(rd_data_ff[csa_pkg::SAMPLE_W-1:0]) *
                  $signed(rd_data_ff[csa_pkg::SAMPLE_W-1:0]);
      power     = {1'b0, unsigned'(im_sq)} + {1'b0, unsigned'(re_sq)};
      rad_in    = {power[csa_pkg::PAIR_W-1:0], {csa_pkg::AMP_W{1'b0}}};
      rem_shift = {rem_ff, rad_ff[csa_pkg::RAD_W-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      take_bit  = (rem_shift >= trial);
      rem_in    = take_bit ? csa_pkg::REM_W'(rem_shift - trial) : csa_pkg::REM_W'(rem_shift);
      root_in   = {root_ff[csa_pkg::AMP_W-2:0], take_bit};
      last_step = (step_ff == {csa_pkg::STEP_W{1'b1}});
      repeat_slot = flag_bad_ff && (slot_ff == csa_pkg::SLOT_W'(csa_pkg::HALF_SLOTS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_COLLECT;
         ap_address_ff     <= '0;
         pair_count_ff     <= '0;
         flag_bad_ff       <= 1'b0;
         address_ok_ff     <= 1'b0;
         record_counter_ff <= '0;
         prev_amp_ff       <= '0;
         slot_ff           <= '0;
         step_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_last_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ap_address_ff <= csr_write_data;
         end
         case (state_ff)
            ST_COLLECT: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  flag_bad_ff   <= flag_bad_in;
                  address_ok_ff <= address_ok_in;
                  pair_count_ff <= req_last_pair ? '0 : pair_count_in;
                  if (req_last_pair && record_ok) begin
                     record_counter_ff <= record_counter_ff + 1'b1;
                     slot_ff           <= '0;
                     state_ff          <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               rsp_valid_ff <= repeat_slot;
               if (repeat_slot) begin
                  rsp_amplitude_ff <= prev_amp_ff;
                  rsp_slot_ff      <= slot_ff;
                  rsp_last_ff      <= 1'b0;
                  slot_ff          <= slot_ff + 1'b1;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               rsp_valid_ff <= 1'b0;
               rad_ff       <= rad_in;
               rem_ff       <= '0;
               root_ff      <= '0;
               step_ff      <= '0;
               state_ff     <= ST_ROOT;
            end
            ST_ROOT: begin
               rsp_valid_ff <= last_step;
               rad_ff       <= {rad_ff[csa_pkg::RAD_W-3:0], 2'b00};
               rem_ff       <= rem_in;
               root_ff      <= root_in;
               step_ff      <= step_ff + 1'b1;
               if (last_step) begin
                  rsp_amplitude_ff <= root_in;
                  prev_amp_ff      <= root_in;
                  rsp_slot_ff      <= slot_ff;
                  rsp_last_ff      <= (slot_ff == csa_pkg::SLOT_W'(csa_pkg::USED_SLOTS - 1));
                  if (slot_ff == csa_pkg::SLOT_W'(csa_pkg::USED_SLOTS - 1)) begin
                     state_ff <= ST_COLLECT;
                  end else begin
                     slot_ff  <= slot_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_COLLECT;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_amplitude      = rsp_amplitude_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_frame_sequence = record_counter_ff;
   assign rsp_last_slot      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_slot != csa_pkg::SLOT_W'(csa_pkg::HALF_SLOTS - 1)) |=> !rsp_valid)
      else $error("results back to back outside the repeated slot");

   a_busy_until_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_slot |-> busy)
      else $error("unit went idle before the last slot");

   a_last_is_final : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_slot |-> (rsp_slot == csa_pkg::SLOT_W'(csa_pkg::USED_SLOTS - 1)))
      else $error("last slot flag on wrong slot");

   a_amp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_amplitude <= csa_pkg::AMP_W'(csa_pkg::AMP_MAX)))
      else $error("amplitude out of range");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= csa_pkg::COUNT_W'(csa_pkg::RAW_PAIRS))
      else $error("pair count beyond record size");
`endif

endmodule

>>> test/csi_subcarrier_amplitude_unit_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// csi_subcarrier_amplitude_unit_tb
// Streams channel-state records into the amplitude unit and checks every
// emitted amplitude, slot, sequence number and last-slot flag against an
// in-bench predictor of record capture, address filtering and the Q8.8 root.
// -----------------------------------------------------------------------------
module csi_subcarrier_amplitude_unit_tb;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [csa_pkg::ADDR_W-1:0] ADDR_ALL_ONES = '1;

   typedef struct packed {
      logic [csa_pkg::AMP_W-1:0]  amplitude;
      logic [csa_pkg::SLOT_W-1:0] slot;
      logic [csa_pkg::SEQ_W-1:0]  frame_sequence;
      logic                       last_slot;
   } amp_result_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [csa_pkg::SAMPLE_W-1:0] req_imag;
   logic signed [csa_pkg::SAMPLE_W-1:0] req_real_req;
   logic                                req_first_word_bad;
   logic [csa_pkg::ADDR_W-1:0]          req_frame_address;
   logic                                req_last_pair;
   logic                                rsp_valid;
   logic [csa_pkg::AMP_W-1:0]           rsp_amplitude;
   logic [csa_pkg::SLOT_W-1:0]          rsp_slot;
   logic [csa_pkg::SEQ_W-1:0]           rsp_frame_sequence;
   logic                                rsp_last_slot;
   logic                                csr_write_enable;
   logic [csa_pkg::ADDR_W-1:0]          csr_write_data;

   amp_result_type             amp_expected[$];
   amp_result_type             amp_want;
   int                         fail_count  = 0;
   int                         idle_cycles = 0;
   int                         pairs_sent  = 0;
   logic [csa_pkg::PAIR_W-1:0] pair_plan [0:127];

   logic [csa_pkg::PAIR_W-1:0] pair_mem [0:csa_pkg::RAW_PAIRS-1];
   int                         held_pairs  = 0;
   logic                       rec_bad     = 1'b0;
   logic                       rec_addr_ok = 1'b0;
   logic [csa_pkg::SEQ_W-1:0]  record_seq  = '0;
   logic [csa_pkg::AMP_W-1:0]  last_amp    = '0;
   logic [csa_pkg::ADDR_W-1:0] ap_model    = '0;

   csi_subcarrier_amplitude_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_imag           (req_imag),
      .req_real_req       (req_real_req),
      .req_first_word_bad (req_first_word_bad),
      .req_frame_address  (req_frame_address),
      .req_last_pair      (req_last_pair),
      .rsp_valid          (rsp_valid),
      .rsp_amplitude      (rsp_amplitude),
      .rsp_slot           (rsp_slot),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_last_slot      (rsp_last_slot),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [csa_pkg::AMP_W-1:0] pair_amplitude(
         logic [csa_pkg::PAIR_W-1:0] p);
      int     im_v;
      int     re_v;
      longint power_q;
      longint root;
      longint trial;
      im_v    = $signed(p[15:8]);
      re_v    = $signed(p[7:0]);
      power_q = longint'(im_v * im_v + re_v * re_v) << 16;
      root    = 0;
      for (int b = csa_pkg::AMP_W - 1; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= power_q) root = trial;
      end
      return root[csa_pkg::AMP_W-1:0];
   endfunction

   function automatic void predict_pair(logic [7:0] im, logic [7:0] re, logic bad,
                                        logic [csa_pkg::ADDR_W-1:0] addr, logic is_last);
      int                        raw;
      logic [csa_pkg::AMP_W-1:0] amp;
      amp_result_type            r;
      if (held_pairs == 0) begin
         rec_bad     = bad;
         rec_addr_ok = (addr == ap_model);
      end
      if (held_pairs < csa_pkg::RAW_PAIRS) begin
         pair_mem[held_pairs] = {im, re};
         held_pairs++;
      end
      if (!is_last) return;
      if (!rec_addr_ok || held_pairs < csa_pkg::RAW_PAIRS) begin
         held_pairs = 0;
         return;
      end
      held_pairs = 0;
      record_seq++;
      for (int k = 0; k < csa_pkg::USED_SLOTS; k++) begin
         raw = (k < csa_pkg::HALF_SLOTS) ? csa_pkg::NEG_BASE + k
                                         : k - csa_pkg::HALF_SLOTS + 1;
         if (rec_bad && raw == 1) amp = last_amp;
         else amp = pair_amplitude(pair_mem[raw]);
         last_amp           = amp;
         r.amplitude        = amp;
         r.slot             = csa_pkg::SLOT_W'(k);
         r.frame_sequence   = record_seq;
         r.last_slot        = (k == csa_pkg::USED_SLOTS - 1);
         amp_expected.push_back(r);
      end
   endfunction

   function automatic logic [csa_pkg::ADDR_W-1:0] rand48();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   function automatic logic [7:0] extreme_byte(int sel);
      case (sel % 4)
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic void fill_plan_random();
      for (int i = 0; i < 128; i++) begin
         pair_plan[i] = 16'($urandom());
         if ($urandom_range(7) == 0) pair_plan[i][15:8] = extreme_byte($urandom_range(3));
         if ($urandom_range(7) == 0) pair_plan[i][7:0]  = extreme_byte($urandom_range(3));
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (amp_expected.size() == 0) begin
            $error("unexpected result: slot %0d amplitude %0d", rsp_slot, rsp_amplitude);
            fail_count++;
         end else begin
            amp_want = amp_expected.pop_front();
            if (rsp_amplitude !== amp_want.amplitude) begin
               $error("amplitude: expected %0d, got %0d", amp_want.amplitude, rsp_amplitude);
               fail_count++;
            end
            if (rsp_slot !== amp_want.slot) begin
               $error("slot: expected %0d, got %0d", amp_want.slot, rsp_slot);
               fail_count++;
            end
            if (rsp_frame_sequence !== amp_want.frame_sequence) begin
               $error("frame_sequence: expected %0d, got %0d",
                      amp_want.frame_sequence, rsp_frame_sequence);
               fail_count++;
            end
            if (rsp_last_slot !== amp_want.last_slot) begin
               $error("last_slot: expected %0d, got %0d", amp_want.last_slot, rsp_last_slot);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_pair(input logic [7:0] im, input logic [7:0] re, input logic bad,
                            input logic [csa_pkg::ADDR_W-1:0] addr, input logic is_last);
      req_imag           <= im;
      req_real_req       <= re;
      req_first_word_bad <= bad;
      req_frame_address  <= addr;
      req_last_pair      <= is_last;
      start              <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pair(im, re, bad, addr, is_last);
      pairs_sent++;
   endtask

   task automatic send_record(input int n, input logic bad,
                              input logic [csa_pkg::ADDR_W-1:0] addr, input int idle_pct);
      logic [csa_pkg::ADDR_W-1:0] addr_i;
      logic                       bad_i;
      for (int i = 0; i < n; i++) begin
         while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
         addr_i = (i == 0) ? addr : ($urandom_range(1) ? ap_model : rand48());
         bad_i  = (i == 0) ? bad : 1'($urandom_range(1));
         send_pair(pair_plan[i][15:8], pair_plan[i][7:0], bad_i, addr_i, i == n - 1);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (amp_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ap(input logic [csa_pkg::ADDR_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ap_model = value;
   endtask

   task automatic test_directed_records();
      write_ap('0);
      pair_plan[0] = {8'h80, 8'h80};
      pair_plan[1] = {8'h7F, 8'h7F};
      pair_plan[2] = {8'h00, 8'hFF};
      send_record(3, 1'b1, '0, 0);
      send_record(1, 1'b0, '0, 0);
      for (int i = 0; i < 128; i++)
         pair_plan[i] = {extreme_byte(i), extreme_byte(i / 4)};
      send_record(csa_pkg::RAW_PAIRS, 1'b0, '0, 0);
      fill_plan_random();
      send_record(csa_pkg::RAW_PAIRS + 2, 1'b1, '0, 0);
      send_record(csa_pkg::RAW_PAIRS, 1'b0, ADDR_ALL_ONES, 0);
      drain_results();
   endtask

   task automatic run_random_records(input int idle_pct,
                                     input logic [csa_pkg::ADDR_W-1:0] ap_value,
                                     input int n_items);
      int                         first_count;
      int                         kind;
      int                         n;
      logic [csa_pkg::ADDR_W-1:0] flip;
      drain_results();
      write_ap(ap_value);
      first_count = pairs_sent;
      while (pairs_sent - first_count < n_items) begin
         kind = $urandom_range(99);
         fill_plan_random();
         if (kind < 70) begin
            n = ($urandom_range(3) == 0)
                ? $urandom_range(csa_pkg::RAW_PAIRS + 1, csa_pkg::RAW_PAIRS + 8)
                : csa_pkg::RAW_PAIRS;
            send_record(n, 1'($urandom_range(1)), ap_model, idle_pct);
         end else if (kind < 85) begin
            send_record($urandom_range(1, csa_pkg::RAW_PAIRS - 1), 1'($urandom_range(1)),
                        ap_model, idle_pct);
         end else begin
            flip = rand48();
            if (flip == '0) flip = csa_pkg::ADDR_W'(1);
            send_record(csa_pkg::RAW_PAIRS + $urandom_range(2), 1'($urandom_range(1)),
                        ap_model ^ flip, idle_pct);
         end
      end
   endtask

   task automatic test_random_sparse_sender();
      run_random_records(23, ADDR_ALL_ONES, 70);
   endtask

   task automatic test_random_busy_sender();
      run_random_records(76, rand48(), 70);
   endtask

   task automatic test_random_back_to_back();
      run_random_records(0, rand48(), 70);
   endtask

   initial begin
      reset              <= 1'b1;
      start              <= 1'b0;
      req_imag           <= '0;
      req_real_req       <= '0;
      req_first_word_bad <= 1'b0;
      req_frame_address  <= '0;
      req_last_pair      <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_records();
      test_random_sparse_sender();
      test_random_busy_sender();
      test_random_back_to_back();
      drain_results();
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

>>> csi_subcarrier_amplitude_unit.f
hdl/csa_pkg.sv
hdl/csi_subcarrier_amplitude_unit.sv
test/csi_subcarrier_amplitude_unit_tb.sv
